@@ src/dual_supply_window_supervisor_defines.svh @@
// assertion macros for the dual supply window supervisor
`ifndef DUAL_SUPPLY_WINDOW_SUPERVISOR_DEFINES_SVH
`define DUAL_SUPPLY_WINDOW_SUPERVISOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DSWS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define DSWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/dsws_pkg.sv @@
// shared types and constants for the dual supply window supervisor
`default_nettype none

package dsws_pkg;

  localparam int unsigned MV_W      = 16;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSE_LOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSE_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY_MARG  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSE_MARG   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY_FLIM  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSE_FLIM   = 3'd7;

  // configuration reset values
  localparam logic [MV_W-1:0]  RST_LOW_LIMIT   = 16'd0;
  localparam logic [MV_W-1:0]  RST_HIGH_LIMIT  = 16'hFFFF;
  localparam logic [MV_W-1:0]  RST_MARGIN      = 16'd0;
  localparam logic [CNT_W-1:0] RST_FAULT_LIMIT = 8'd3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // phase codes as seen on the result
  localparam logic [1:0] PHASE_CODE_STARTUP = 2'd0;
  localparam logic [1:0] PHASE_CODE_RUN     = 2'd1;
  localparam logic [1:0] PHASE_CODE_STOP    = 2'd2;

  typedef enum logic [2:0] {
    PH_STARTUP = 3'b001,
    PH_RUN     = 3'b010,
    PH_STOP    = 3'b100
  } phase_t;

  typedef struct packed {
    logic [MV_W-1:0] supply_mv;
    logic [MV_W-1:0] sense_mv;
  } in_item_t;

  typedef struct packed {
    logic       power_enable;
    logic       stopped;
    logic       supply_out_of_window;
    logic       sense_out_of_window;
    logic [1:0] phase_now;
  } out_item_t;

  // window check results handed to the control unit
  typedef struct packed {
    logic supply_bad;
    logic sense_bad;
  } chk_t;

endpackage

`default_nettype wire

@@ src/dual_supply_window_supervisor.sv @@
// top level of the dual supply window supervisor
//
//  port group | dir | handshake          | payload
//  in_        | in  | in_valid/in_ready  | in_data    (supply_mv, sense_mv)
//  out_       | out | out_valid/out_ready| out_data   (enable, stopped, flags, phase)
//  cfg_       | in  | cfg_we             | cfg_index, cfg_wdata
//
// one item per cycle sustained while out_ready stays high; an item goes through
// the input register, then the window compares and counter update, and lands in
// the result register once that register is free to take it
// synchronous active-low reset clears phase, counters, enable and both valids,
// and puts the configuration registers to their defaults
// a stalled result holds the result register; the input register still takes
// an item as long as it can move on, so no bubble appears under stall release
`default_nettype none
`include "dual_supply_window_supervisor_defines.svh"

module dual_supply_window_supervisor
  import dsws_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // sample input
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  // result output
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data,
  // configuration writes
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata
);

  // configuration registers
  logic [MV_W-1:0]  sup_low_r, sup_high_r, sns_low_r, sns_high_r;
  logic [MV_W-1:0]  sup_marg_r, sns_marg_r;
  logic [CNT_W-1:0] sup_flim_r, sns_flim_r;

  // input stage
  in_item_t  in_data_r;
  logic      in_valid_r, in_valid_nxt;

  // result stage
  out_item_t out_data_r;
  logic      out_valid_r, out_valid_nxt;

  logic      res_free;   // result register can take an item this cycle
  logic      fire;       // item moves from input register to result register
  logic      in_acc;
  logic      run_mode;
  chk_t      chk;
  out_item_t result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sup_low_r  <= RST_LOW_LIMIT;
      sup_high_r <= RST_HIGH_LIMIT;
      sns_low_r  <= RST_LOW_LIMIT;
      sns_high_r <= RST_HIGH_LIMIT;
      sup_marg_r <= RST_MARGIN;
      sns_marg_r <= RST_MARGIN;
      sup_flim_r <= RST_FAULT_LIMIT;
      sns_flim_r <= RST_FAULT_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SUPPLY_LOW:  sup_low_r  <= cfg_wdata;
        CFG_SUPPLY_HIGH: sup_high_r <= cfg_wdata;
        CFG_SENSE_LOW:   sns_low_r  <= cfg_wdata;
        CFG_SENSE_HIGH:  sns_high_r <= cfg_wdata;
        CFG_SUPPLY_MARG: sup_marg_r <= cfg_wdata;
        CFG_SENSE_MARG:  sns_marg_r <= cfg_wdata;
        CFG_SUPPLY_FLIM: sup_flim_r <= cfg_wdata[CNT_W-1:0];
        CFG_SENSE_FLIM:  sns_flim_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign res_free = !out_valid_r || out_ready;
  assign fire     = in_valid_r && res_free;
  assign in_ready = !in_valid_r || res_free;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    in_valid_nxt  = in_acc || (in_valid_r && !fire);
    out_valid_nxt = fire || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= result;
    end
  end

  // window checks, strict at startup and widened in run mode
  dsws_window u_supply_win (
    .reading    (in_data_r.supply_mv),
    .low_limit  (sup_low_r),
    .high_limit (sup_high_r),
    .margin     (sup_marg_r),
    .widen      (run_mode),
    .bad        (chk.supply_bad)
  );

  dsws_window u_sense_win (
    .reading    (in_data_r.sense_mv),
    .low_limit  (sns_low_r),
    .high_limit (sns_high_r),
    .margin     (sns_marg_r),
    .widen      (run_mode),
    .bad        (chk.sense_bad)
  );

  // phase, fault counters and enable; state moves on when the item does
  dsws_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .fire               (fire),
    .chk                (chk),
    .supply_fault_limit (sup_flim_r),
    .sense_fault_limit  (sns_flim_r),
    .run_mode           (run_mode),
    .result             (result)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a stopped result is never followed by one that is not stopped
  `DSWS_ASSERT_NEXT(a_stop_latches,
                    out_valid_r && out_ready && out_data_r.stopped,
                    !out_valid_r || out_data_r.stopped,
                    "stopped released before reset")

  // a stopped result never carries the enable
  `DSWS_ASSERT_NOW(a_stop_no_enable,
                   out_valid_r && out_data_r.stopped,
                   !out_data_r.power_enable && (out_data_r.phase_now == PHASE_CODE_STOP),
                   "enable or phase wrong while stopped")

  // the enable only shows in run mode
  `DSWS_ASSERT_NOW(a_enable_in_run,
                   out_valid_r && out_data_r.power_enable,
                   out_data_r.phase_now == PHASE_CODE_RUN,
                   "enable outside run mode")

  // an accepted item is held in the input register
  `DSWS_ASSERT_NEXT(a_in_captured, in_acc, in_valid_r, "accepted item lost")

endmodule

`default_nettype wire

@@ src/dsws_window.sv @@
// window compare for one rail, margin applied only in run mode
`default_nettype none

module dsws_window
  import dsws_pkg::*;
(
  input  wire logic [MV_W-1:0] reading,
  input  wire logic [MV_W-1:0] low_limit,
  input  wire logic [MV_W-1:0] high_limit,
  input  wire logic [MV_W-1:0] margin,
  input  wire logic            widen,
  output logic                 bad
);

  logic [MV_W-1:0] marg_eff;
  logic [MV_W-1:0] low_bound;
  logic [MV_W:0]   high_bound;

  always_comb begin
    marg_eff   = widen ? margin : '0;
    // low bound saturates at zero
    low_bound  = (low_limit > marg_eff) ? (low_limit - marg_eff) : '0;
    // high bound keeps its carry, no wrap
    high_bound = {1'b0, high_limit} + {1'b0, marg_eff};
    bad        = (reading <= low_bound) || ({1'b0, reading} >= high_bound);
  end

endmodule

`default_nettype wire

@@ src/dsws_ctrl.sv @@
// phase sequencing, fault counters and enable for the supervisor
`default_nettype none

module dsws_ctrl
  import dsws_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire chk_t             chk,
  input  wire logic [CNT_W-1:0] supply_fault_limit,
  input  wire logic [CNT_W-1:0] sense_fault_limit,
  output logic                  run_mode,
  output out_item_t             result
);

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] sup_run_r, sup_run_nxt;
  logic [CNT_W-1:0] sns_run_r, sns_run_nxt;
  logic             enable_r, enable_nxt;
  logic             sup_bad, sns_bad;

  assign run_mode = (phase_r == PH_RUN);

  always_comb begin
    phase_nxt   = phase_r;
    sup_run_nxt = sup_run_r;
    sns_run_nxt = sns_run_r;
    enable_nxt  = enable_r;
    sup_bad     = 1'b0;
    sns_bad     = 1'b0;
    case (phase_r)
      PH_STARTUP: begin
        sup_bad = chk.supply_bad;
        sns_bad = chk.sense_bad;
        if (sup_bad || sns_bad) begin
          phase_nxt = PH_STOP;
        end else begin
          phase_nxt  = PH_RUN;
          enable_nxt = 1'b1;
        end
      end
      PH_RUN: begin
        sup_bad = chk.supply_bad;
        sns_bad = chk.sense_bad;
        if (!sup_bad) begin
          sup_run_nxt = '0;
        end else if (sup_run_r != CNT_MAX) begin
          sup_run_nxt = sup_run_r + 1'b1;
        end
        if (!sns_bad) begin
          sns_run_nxt = '0;
        end else if (sns_run_r != CNT_MAX) begin
          sns_run_nxt = sns_run_r + 1'b1;
        end
        if ((sup_run_nxt >= supply_fault_limit) || (sns_run_nxt >= sense_fault_limit)) begin
          enable_nxt = 1'b0;
          phase_nxt  = PH_STOP;
        end
      end
      default: begin
        phase_nxt  = PH_STOP;
        enable_nxt = 1'b0;
      end
    endcase

    result.power_enable         = enable_nxt;
    result.stopped              = (phase_nxt == PH_STOP);
    result.supply_out_of_window = sup_bad;
    result.sense_out_of_window  = sns_bad;
    case (phase_nxt)
      PH_STARTUP: result.phase_now = PHASE_CODE_STARTUP;
      PH_RUN:     result.phase_now = PHASE_CODE_RUN;
      default:    result.phase_now = PHASE_CODE_STOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_STARTUP;
      sup_run_r <= '0;
      sns_run_r <= '0;
      enable_r  <= 1'b0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      sup_run_r <= sup_run_nxt;
      sns_run_r <= sns_run_nxt;
      enable_r  <= enable_nxt;
    end
  end

endmodule

`default_nettype wire
